/* design/slt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants for the slew limited tachometer.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int SUM_WIDTH  = 48;
    localparam int SPEED_W    = 16 + FRAC_BITS;
    localparam int TIME_W     = 32;
    localparam int RPM_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // shared divider geometry
    localparam int DIV_DVD_W  = SUM_WIDTH;
    localparam int DIV_DSR_W  = 21;
    localparam int DIV_CNT_W  = 6;
    localparam int TGT_STEPS  = SPEED_W;

    // 60000 rpm scaled to the fixed point grid
    localparam logic [SPEED_W-1:0] RPM_SCALED = SPEED_W'(60000 * (2 ** FRAC_BITS));
    localparam logic [SPEED_W-1:0] HALF_LSB   = SPEED_W'(2 ** (FRAC_BITS - 1));

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPD_INT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STALL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PPR      = 3'd4;

    // register reset values
    localparam logic [7:0]  DEBOUNCE_RST = 8'd10;
    localparam logic [9:0]  UPD_INT_RST  = 10'd33;
    localparam logic [9:0]  SLEW_RST     = 10'd10;
    localparam logic [15:0] STALL_RST    = 16'd2000;
    localparam logic [4:0]  PPR_RST      = 5'd2;

    typedef struct packed {
        logic pulse_edge;
        logic log_request;
    } in_item_t;

    typedef struct packed {
        logic [RPM_W-1:0] speed_rpm;
        logic             speed_updated;
        logic [RPM_W-1:0] average_rpm;
        logic             average_valid;
    } out_item_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

/* design/slt_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_div
// Restoring divider, one quotient bit per cycle, shared by the average
// and the target speed computation.
// ----------------------------------------------------------------------------
module slt_div (
    input  wire               clk,
    input  wire               rst_n,
    input  slt_pkg::div_req_t req,
    output slt_pkg::div_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [slt_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [slt_pkg::DIV_DVD_W-1:0] dvd_reg, dvd_next;
    logic [slt_pkg::DIV_DSR_W-1:0] rem_reg, rem_next;
    logic [slt_pkg::DIV_DSR_W-1:0] dsr_reg, dsr_next;

    logic [slt_pkg::DIV_DSR_W:0]   trial;
    logic                          ge;

    assign trial = {rem_reg, dvd_reg[slt_pkg::DIV_DVD_W-1]};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            dvd_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the top trial bit drops out
            rem_next = ge ? slt_pkg::DIV_DSR_W'(trial - {1'b0, dsr_reg})
                          : trial[slt_pkg::DIV_DSR_W-1:0];
            dvd_next = {dvd_reg[slt_pkg::DIV_DVD_W-2:0], ge};
            cnt_next = cnt_reg - slt_pkg::DIV_CNT_W'(1);
            if (cnt_reg == slt_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule
`default_nettype wire

/* design/slew_limited_tachometer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slew_limited_tachometer_unit
// Period measuring tachometer with slew limited speed estimate and average.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item is one millisecond tick (pulse_edge, log_request) on the
//   in_valid/in_ready channel. Each tick yields exactly one output item on
//   out_valid/out_ready with the current speed, an update flag and, on a log
//   request, the rounded average since the previous request.
//   Registers are written through cfg_we/cfg_index/cfg_wdata, by the user only
//   while idle, a rule the block has no check for; indexes beyond the register list are ignored.
//   A tick with a log request or an update may run the shared divider and so
//   takes longer than a tick with neither. One restoring divider, one
//   quotient bit per cycle, serves both: 48 steps for the average and 24 for
//   the target speed. in_ready is high only while the sequencer is idle.
//   The result sits in an output register; if the receiver stalls, the
//   block already accepts the next tick and holds its finished result until
//   the register frees up.
//   Reset loads the default register values and clears time, speed, sum
//   and count.
// ----------------------------------------------------------------------------
module slew_limited_tachometer_unit (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  slt_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output slt_pkg::out_item_t                  out_data,
    input  wire                                 cfg_we,
    input  wire  [slt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [slt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_LOG     = 9'b000000010,
        S_LOG_DIV = 9'b000000100,
        S_UPD     = 9'b000001000,
        S_TGT     = 9'b000010000,
        S_TGT_DIV = 9'b000100000,
        S_SLEW    = 9'b001000000,
        S_ACC     = 9'b010000000,
        S_DONE    = 9'b100000000
    } state_t;

    localparam int SW = slt_pkg::SPEED_W;
    localparam int FB = slt_pkg::FRAC_BITS;
    localparam int SM = slt_pkg::SUM_WIDTH;
    localparam int TW = slt_pkg::TIME_W;

    state_t state_reg, state_next;

    logic [7:0]  debounce_reg, debounce_next;
    logic [9:0]  upd_int_reg, upd_int_next;
    logic [9:0]  slew_reg, slew_next;
    logic [15:0] stall_reg, stall_next;
    logic [4:0]  ppr_reg, ppr_next;

    logic [TW-1:0] now_reg, now_next;
    logic [TW-1:0] last_pulse_reg, last_pulse_next;
    logic [TW-1:0] consumed_reg, consumed_next;
    logic [TW-1:0] last_update_reg, last_update_next;
    logic [SW-1:0] speed_reg, speed_next;
    logic [SM-1:0] sum_reg, sum_next;
    logic [15:0]   count_reg, count_next;

    logic                     log_req_reg, log_req_next;
    logic                     updated_reg, updated_next;
    logic [slt_pkg::RPM_W-1:0] avg_reg, avg_next;
    logic                     iv_ok_reg, iv_ok_next;
    logic                     stalled_reg, stalled_next;
    logic [20:0]              d_reg, d_next;
    logic [19:0]              lim_prod_reg, lim_prod_next;
    logic [SW-1:0]            target_reg, target_next;

    logic               out_valid_reg, out_valid_next;
    slt_pkg::out_item_t out_data_reg, out_data_next;

    slt_pkg::div_req_t div_req;
    slt_pkg::div_rsp_t div_rsp;

    // datapath helpers
    logic [TW-1:0]   since_pulse;
    logic [TW-1:0]   since_update;
    logic [TW-1:0]   interval;
    logic [4:0]      ppr_eff;
    logic [SM:0]     avg_sum;
    logic [SM-FB:0]  avg_shift;
    logic [SW-1:0]   tgt_num;
    logic [SW+3:0]   limit_full;
    logic [SW-1:0]   delta_up;
    logic [SW-1:0]   delta_dn;
    logic [SW-1:0]   step_up;
    logic [SW-1:0]   step_dn;
    logic [SW-1:0]   slewed;
    logic [SM:0]     sum_ext;
    logic [SW:0]     speed_round;

    assign since_pulse  = now_reg - last_pulse_reg;
    assign since_update = now_reg - last_update_reg;
    assign interval     = last_pulse_reg - consumed_reg;
    assign ppr_eff      = (ppr_reg == 5'd0) ? 5'd1 : ppr_reg;

    assign avg_sum   = {1'b0, div_rsp.quotient} + (SM + 1)'(slt_pkg::HALF_LSB);
    assign avg_shift = avg_sum[SM:FB];

    assign tgt_num = slt_pkg::RPM_SCALED + SW'(d_reg[20:1]);

    assign limit_full = {lim_prod_reg, {FB{1'b0}}};
    assign delta_up   = target_reg - speed_reg;
    assign delta_dn   = speed_reg - target_reg;
    // when the delta exceeds the limit, the limit fits the speed width
    assign step_up = ((SW + 4)'(delta_up) > limit_full) ? limit_full[SW-1:0] : delta_up;
    assign step_dn = ((SW + 4)'(delta_dn) > limit_full) ? limit_full[SW-1:0] : delta_dn;
    assign slewed  = (target_reg > speed_reg) ? speed_reg + step_up : speed_reg - step_dn;

    assign sum_ext     = {1'b0, sum_reg} + (SM + 1)'(speed_reg);
    assign speed_round = {1'b0, speed_reg} + (SW + 1)'(slt_pkg::HALF_LSB);

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.steps    = slt_pkg::DIV_CNT_W'(SM);
        div_req.dividend = sum_reg;
        div_req.divisor  = slt_pkg::DIV_DSR_W'(count_reg);
        if (state_reg == S_TGT)
        begin
            div_req.start    = iv_ok_reg;
            div_req.steps    = slt_pkg::DIV_CNT_W'(slt_pkg::TGT_STEPS);
            div_req.dividend = {tgt_num, {(SM - SW){1'b0}}};
            div_req.divisor  = d_reg;
        end
        else if (state_reg == S_LOG)
        begin
            div_req.start = log_req_reg && (count_reg != 16'd0);
        end
    end

    slt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next       = state_reg;
        debounce_next    = debounce_reg;
        upd_int_next     = upd_int_reg;
        slew_next        = slew_reg;
        stall_next       = stall_reg;
        ppr_next         = ppr_reg;
        now_next         = now_reg;
        last_pulse_next  = last_pulse_reg;
        consumed_next    = consumed_reg;
        last_update_next = last_update_reg;
        speed_next       = speed_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        log_req_next     = log_req_reg;
        updated_next     = updated_reg;
        avg_next         = avg_reg;
        iv_ok_next       = iv_ok_reg;
        stalled_next     = stalled_reg;
        d_next           = d_reg;
        lim_prod_next    = lim_prod_reg;
        target_next      = target_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        if (cfg_we)
        begin
            case (cfg_index)
                slt_pkg::REG_DEBOUNCE: debounce_next = cfg_wdata[7:0];
                slt_pkg::REG_UPD_INT:  upd_int_next  = cfg_wdata[9:0];
                slt_pkg::REG_SLEW:     slew_next     = cfg_wdata[9:0];
                slt_pkg::REG_STALL:    stall_next    = cfg_wdata[15:0];
                slt_pkg::REG_PPR:      ppr_next      = cfg_wdata[4:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.pulse_edge && (since_pulse > TW'(debounce_reg)))
                        last_pulse_next = now_reg;
                    log_req_next = in_data.log_request;
                    updated_next = 1'b0;
                    avg_next     = '0;
                    state_next   = S_LOG;
                end
            end
            S_LOG:
            begin
                if (log_req_reg && (count_reg != 16'd0))
                begin
                    state_next = S_LOG_DIV;
                end
                else
                begin
                    if (log_req_reg)
                    begin
                        sum_next   = '0;
                        count_next = '0;
                    end
                    state_next = S_UPD;
                end
            end
            S_LOG_DIV:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = (|avg_shift[SM-FB:16]) ? 16'hFFFF : avg_shift[15:0];
                    sum_next   = '0;
                    count_next = '0;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (since_update >= TW'(upd_int_reg))
                begin
                    last_update_next = now_reg;
                    updated_next     = 1'b1;
                    iv_ok_next       = (interval != '0) && (interval < TW'(stall_reg));
                    if ((interval != '0) && (interval < TW'(stall_reg)))
                        consumed_next = last_pulse_reg;
                    d_next        = 21'(interval[15:0]) * 21'(ppr_eff);
                    lim_prod_next = 20'(slew_reg) * 20'(upd_int_reg);
                    stalled_next  = since_pulse > TW'(stall_reg);
                    state_next    = S_TGT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_TGT:
            begin
                if (iv_ok_reg)
                begin
                    state_next = S_TGT_DIV;
                end
                else
                begin
                    target_next = '0;
                    state_next  = S_SLEW;
                end
            end
            S_TGT_DIV:
            begin
                if (div_rsp.done)
                begin
                    target_next = div_rsp.quotient[SW-1:0];
                    state_next  = S_SLEW;
                end
            end
            S_SLEW:
            begin
                speed_next = stalled_reg ? '0 : slewed;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sum_next = sum_ext[SM] ? {SM{1'b1}} : sum_ext[SM-1:0];
                if (count_reg != 16'hFFFF)
                    count_next = count_reg + 16'd1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.speed_rpm     = speed_round[FB+slt_pkg::RPM_W-1:FB];
                    out_data_next.speed_updated = updated_reg;
                    out_data_next.average_rpm   = avg_reg;
                    out_data_next.average_valid = log_req_reg;
                    now_next                    = now_reg + TW'(1);
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            debounce_reg    <= slt_pkg::DEBOUNCE_RST;
            upd_int_reg     <= slt_pkg::UPD_INT_RST;
            slew_reg        <= slt_pkg::SLEW_RST;
            stall_reg       <= slt_pkg::STALL_RST;
            ppr_reg         <= slt_pkg::PPR_RST;
            now_reg         <= '0;
            last_pulse_reg  <= '0;
            consumed_reg    <= '0;
            last_update_reg <= '0;
            speed_reg       <= '0;
            sum_reg         <= '0;
            count_reg       <= '0;
            log_req_reg     <= 1'b0;
            updated_reg     <= 1'b0;
            iv_ok_reg       <= 1'b0;
            stalled_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            debounce_reg    <= debounce_next;
            upd_int_reg     <= upd_int_next;
            slew_reg        <= slew_next;
            stall_reg       <= stall_next;
            ppr_reg         <= ppr_next;
            now_reg         <= now_next;
            last_pulse_reg  <= last_pulse_next;
            consumed_reg    <= consumed_next;
            last_update_reg <= last_update_next;
            speed_reg       <= speed_next;
            sum_reg         <= sum_next;
            count_reg       <= count_next;
            log_req_reg     <= log_req_next;
            updated_reg     <= updated_next;
            iv_ok_reg       <= iv_ok_next;
            stalled_reg     <= stalled_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg      <= avg_next;
        d_reg        <= d_next;
        lim_prod_reg <= lim_prod_next;
        target_reg   <= target_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

/* design/slt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_checker
// Port level checks for the slew limited tachometer, bound to the top level.
// ----------------------------------------------------------------------------
module slt_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                in_valid,
    input wire                in_ready,
    input wire                out_valid,
    input wire                out_ready,
    input slt_pkg::out_item_t out_data
);

    // one tick at a time: the input side closes right after an item
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("in_ready stayed high after an accepted item");

    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data))
    ) else $error("stalled output item changed or dropped");

    a_avg_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.average_valid) |-> (out_data.average_rpm == 16'd0)
    ) else $error("average_rpm nonzero without a log request");

    a_speed_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.speed_rpm <= 16'd60000)
    ) else $error("speed_rpm above full scale");

endmodule

bind slew_limited_tachometer_unit slt_checker u_slt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
